FILE: rtl/idct8_pkg.sv
// idct8_pkg: widths, types, the 8-point integer basis and the pipeline tag
// shared by the 8x8 inverse transform block
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package idct8_pkg;

	localparam int LANES     = 8;
	localparam int COEF_W    = 16;
	localparam int PIX_W     = 8;
	localparam int ROW_W     = 3;
	localparam int BASIS_W   = 8;
	// |coef| * 89 stays below 2^22, so the product fits 24 bits signed
	localparam int PROD_W    = 24;
	// eight products, column weight sum at most 479: fits 26 bits signed
	localparam int SUM_W     = 26;
	localparam int ROW_SHIFT = 6;
	localparam int COL_SHIFT = 12;
	localparam int PIX_MAX   = 255;

	typedef logic signed [COEF_W-1:0]  coef_t;
	typedef logic        [PIX_W-1:0]   pix_t;
	typedef logic        [ROW_W-1:0]   row_idx_t;
	typedef logic signed [BASIS_W-1:0] basis_t;
	typedef logic signed [SUM_W-1:0]   sum_t;

	// basis[k][n]: weight of frequency k at sample n
	localparam basis_t BASIS [LANES][LANES] = '{
		'{ 8'sd64,  8'sd64,  8'sd64,  8'sd64,  8'sd64,  8'sd64,  8'sd64,  8'sd64},
		'{ 8'sd89,  8'sd75,  8'sd50,  8'sd18, -8'sd18, -8'sd50, -8'sd75, -8'sd89},
		'{ 8'sd83,  8'sd36, -8'sd36, -8'sd83, -8'sd83, -8'sd36,  8'sd36,  8'sd83},
		'{ 8'sd75, -8'sd18, -8'sd89, -8'sd50,  8'sd50,  8'sd89,  8'sd18, -8'sd75},
		'{ 8'sd64, -8'sd64, -8'sd64,  8'sd64,  8'sd64, -8'sd64, -8'sd64,  8'sd64},
		'{ 8'sd50, -8'sd89,  8'sd18,  8'sd75, -8'sd75, -8'sd18,  8'sd89, -8'sd50},
		'{ 8'sd36, -8'sd83,  8'sd83, -8'sd36, -8'sd36,  8'sd83, -8'sd83,  8'sd36},
		'{ 8'sd18, -8'sd50,  8'sd75, -8'sd89,  8'sd89, -8'sd75,  8'sd50, -8'sd18}
	};

	// travels beside the lane pipeline: what the sums in flight belong to
	typedef struct packed {
		logic     valid;
		logic     is_col;
		row_idx_t row;
	} tag_t;

endpackage

`default_nettype wire

FILE: rtl/idct8_if.sv
// idct8_coef_if and idct8_pix_if: valid/ready channels of the transform block
// depends on idct8_pkg
`timescale 1ns / 1ps
`default_nettype none

interface idct8_coef_if import idct8_pkg::*;;
	logic  valid;
	logic  ready;
	coef_t coef_0;
	coef_t coef_1;
	coef_t coef_2;
	coef_t coef_3;
	coef_t coef_4;
	coef_t coef_5;
	coef_t coef_6;
	coef_t coef_7;

	modport source (
		output valid, coef_0, coef_1, coef_2, coef_3, coef_4, coef_5, coef_6, coef_7,
		input  ready
	);
	modport sink (
		input  valid, coef_0, coef_1, coef_2, coef_3, coef_4, coef_5, coef_6, coef_7,
		output ready
	);
endinterface

interface idct8_pix_if import idct8_pkg::*;;
	logic     valid;
	logic     ready;
	pix_t     pixel_0;
	pix_t     pixel_1;
	pix_t     pixel_2;
	pix_t     pixel_3;
	pix_t     pixel_4;
	pix_t     pixel_5;
	pix_t     pixel_6;
	pix_t     pixel_7;
	row_idx_t out_row;
	logic     last_row;

	modport source (
		output valid, pixel_0, pixel_1, pixel_2, pixel_3, pixel_4, pixel_5, pixel_6,
		       pixel_7, out_row, last_row,
		input  ready
	);
	modport sink (
		input  valid, pixel_0, pixel_1, pixel_2, pixel_3, pixel_4, pixel_5, pixel_6,
		       pixel_7, out_row, last_row,
		output ready
	);
endinterface

`default_nettype wire

FILE: rtl/idct8_lane.sv
// idct8_lane: one dot-product lane, eight operands against one basis column,
// products registered in stage 1 and the sum in stage 2
// depends on idct8_pkg
`timescale 1ns / 1ps
`default_nettype none

module idct8_lane import idct8_pkg::*; (
	input  logic     clk,
	input  coef_t    opnd [LANES],
	input  row_idx_t col,
	output sum_t     sum_s2
);

	logic signed [PROD_W-1:0] prod_s1 [LANES];
	sum_t                     sum_d;

	// constant-weight products
	always_ff @(posedge clk) begin
		for (int k = 0; k < LANES; k++) begin
			prod_s1[k] <= PROD_W'(opnd[k]) * PROD_W'(BASIS[k][col]);
		end
	end

	// accumulate the eight products
	always_comb begin
		sum_d = '0;
		for (int k = 0; k < LANES; k++) begin
			sum_d = sum_d + SUM_W'(prod_s1[k]);
		end
	end

	always_ff @(posedge clk) begin
		sum_s2 <= sum_d;
	end

endmodule

`default_nettype wire

FILE: rtl/idct8_merge.sv
// idct8_merge: turns the eight lane sums into an intermediate row
// (shift by 6, wrap to 16 bits) and a pixel row (shift by 12, clamp)
// depends on idct8_pkg
`timescale 1ns / 1ps
`default_nettype none

module idct8_merge import idct8_pkg::*; (
	input  sum_t  sums    [LANES],
	output coef_t mid_row [LANES],
	output pix_t  pixels  [LANES]
);

	localparam int PIXV_W = SUM_W - COL_SHIFT;

	function automatic pix_t clamp_pix(input sum_t s);
		logic signed [PIXV_W-1:0] v;
		begin
			v = $signed(s[SUM_W-1:COL_SHIFT]);
			if (v < 0) begin
				return '0;
			end else if (v > PIX_MAX) begin
				return pix_t'(PIX_MAX);
			end
			return v[PIX_W-1:0];
		end
	endfunction

	// floor shift, then keep the low word or clamp to the pixel range
	always_comb begin
		for (int j = 0; j < LANES; j++) begin
			mid_row[j] = sums[j][ROW_SHIFT +: COEF_W];
			pixels[j]  = clamp_pix(sums[j]);
		end
	end

endmodule

`default_nettype wire

FILE: rtl/idct_8x8_integer.sv
// idct_8x8_integer: 8x8 integer inverse transform, eight coefficient rows in,
// eight pixel rows out per block; eight lanes shared by row and column passes
// depends on idct8_pkg, idct8_if, idct8_lane, idct8_merge
//
//   channel | dir | word                               | handshake
//   coef    | in  | coef_0..coef_7, one coefficient row| valid/ready
//   pix     | out | pixel_0..7, out_row, last_row      | valid/ready
//
// a coefficient word is taken every cycle in the row phase; its row pass
// runs the two lane stages and is then registered into the intermediate store;
// after the eighth word, the column pass starts once the lanes are empty;
// each pixel word goes through issue, products, sum and the output register,
// and the next is issued only once that one-deep output register is empty;
// no coefficient word is taken during the column pass; a stalled output
// holds the column pass, arst_n clears the counters, pipeline tags and valid
`timescale 1ns / 1ps
`default_nettype none

module idct_8x8_integer import idct8_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	idct8_coef_if.sink  coef,
	idct8_pix_if.source pix
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_COL  = 1'b1;

	logic     state_q;
	row_idx_t rows_q;
	row_idx_t col_q;
	tag_t     tag_s1;
	tag_t     tag_s2;
	coef_t    mid_q [LANES][LANES];
	coef_t    in_row [LANES];
	sum_t     sums [LANES];
	coef_t    mid_row [LANES];
	pix_t     pixels [LANES];
	logic     out_valid_q;
	pix_t     pix_q [LANES];
	row_idx_t out_row_q;
	logic     in_acc;
	logic     col_issue;

	assign in_row[0] = coef.coef_0;
	assign in_row[1] = coef.coef_1;
	assign in_row[2] = coef.coef_2;
	assign in_row[3] = coef.coef_3;
	assign in_row[4] = coef.coef_4;
	assign in_row[5] = coef.coef_5;
	assign in_row[6] = coef.coef_6;
	assign in_row[7] = coef.coef_7;

	assign coef.ready = (state_q == S_IDLE);
	assign in_acc     = coef.valid && coef.ready;
	// one pixel row in flight at a time, and only after all row writes landed
	assign col_issue  = (state_q == S_COL) && !tag_s1.valid && !tag_s2.valid
		&& !out_valid_q;

	// lanes: lane j gives column j of either pass
	for (genvar j = 0; j < LANES; j++) begin : g_lane
		coef_t    opnd [LANES];
		row_idx_t col;

		always_comb begin
			for (int k = 0; k < LANES; k++) begin
				opnd[k] = (state_q == S_COL) ? mid_q[k][j] : in_row[k];
			end
			col = (state_q == S_COL) ? col_q : row_idx_t'(j);
		end

		idct8_lane u_lane (
			.clk    (clk),
			.opnd   (opnd),
			.col    (col),
			.sum_s2 (sums[j])
		);
	end

	idct8_merge u_merge (
		.sums    (sums),
		.mid_row (mid_row),
		.pixels  (pixels)
	);

	// block sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rows_q  <= '0;
			col_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						rows_q <= ROW_W'(rows_q + 1'b1);
						if (rows_q == row_idx_t'(LANES - 1)) begin
							state_q <= S_COL;
							col_q   <= '0;
						end
					end
				end
				S_COL: begin
					if (col_issue) begin
						col_q <= ROW_W'(col_q + 1'b1);
						if (col_q == row_idx_t'(LANES - 1)) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// tags follow the lane stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
		end else begin
			tag_s1.valid  <= in_acc || col_issue;
			tag_s1.is_col <= col_issue;
			tag_s1.row    <= col_issue ? col_q : rows_q;
			tag_s2        <= tag_s1;
		end
	end

	// intermediate store, one row written per finished row pass
	always_ff @(posedge clk) begin
		if (tag_s2.valid && !tag_s2.is_col) begin
			for (int j = 0; j < LANES; j++) begin
				mid_q[tag_s2.row][j] <= mid_row[j];
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (tag_s2.valid && tag_s2.is_col) begin
			out_valid_q <= 1'b1;
		end else if (pix.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tag_s2.valid && tag_s2.is_col) begin
			pix_q     <= pixels;
			out_row_q <= tag_s2.row;
		end
	end

	assign pix.valid    = out_valid_q;
	assign pix.pixel_0  = pix_q[0];
	assign pix.pixel_1  = pix_q[1];
	assign pix.pixel_2  = pix_q[2];
	assign pix.pixel_3  = pix_q[3];
	assign pix.pixel_4  = pix_q[4];
	assign pix.pixel_5  = pix_q[5];
	assign pix.pixel_6  = pix_q[6];
	assign pix.pixel_7  = pix_q[7];
	assign pix.out_row  = out_row_q;
	assign pix.last_row = (out_row_q == row_idx_t'(LANES - 1));

	// a pixel row never lands on a word that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(tag_s2.valid && tag_s2.is_col) |-> !out_valid_q)
		else $error("pixel row overwrote a pending output word");

	// rows before the last leave while the column pass is still running
	a_col_running: assert property (@(posedge clk) disable iff (!arst_n)
		(pix.valid && pix.ready && !pix.last_row) |-> (state_q == S_COL))
		else $error("column pass ended before its last row");

	// the row counter has wrapped for the whole column pass
	a_rows_wrapped: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COL) |-> (rows_q == '0))
		else $error("row counter moved during column pass");

	// the first column issue reads a store whose last row has already been written
	a_row_landed: assert property (@(posedge clk) disable iff (!arst_n)
		(col_issue && col_q == '0) |-> !$past(tag_s1.valid && !tag_s1.is_col))
		else $error("column pass started over a row still in flight");

endmodule

`default_nettype wire
